### src/pida_pkg.sv
// Shared types and codes for the positional insert/delete array.
package pida_pkg;

    typedef enum logic [2:0] {
        CMD_CLEAR  = 3'd0,
        CMD_APPEND = 3'd1,
        CMD_INSERT = 3'd2,
        CMD_DELETE = 3'd3,
        CMD_READ   = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_APPEND = 2'd1,
        OP_INSERT = 2'd2,
        OP_DELETE = 2'd3
    } store_op_t;

    typedef struct packed {
        store_op_t op;
        status_t   status;
        logic      rd_en;
    } ctrl_t;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned POS_W  = 4;
    localparam int unsigned FUNC_W = 3;

endpackage

### src/positional_insert_delete_array_top.sv
// Top level of the positional insert/delete array: command and result registers.
//
// The block keeps an ordered array of up to CAPACITY signed 32-bit words and a
// count. Each transaction on the s_ channel carries one command (clear, append,
// insert at a position, delete at a position, read at a position), and each
// command yields exactly one transaction on the m_ channel with the word read
// or deleted, the count after the command and a status code. A failing command
// leaves the array and count unchanged.
// A command is captured in an input register, decoded and applied to the
// entry registers, where all entries shift in parallel, and its result is
// held in an output register, which drives m_valid. One command is accepted
// in every cycle while the receiver takes the results.
// When the receiver stalls, the result stays in the output register and one
// more command waits in the input register; s_ready then falls until the
// result is taken. Reset empties both registers and sets the count to zero;
// the entry contents are not cleared and are only read below the count.
module positional_insert_delete_array_top #(
    parameter int unsigned CAPACITY = 16,
    localparam int unsigned CW = $clog2(CAPACITY + 1)
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [pida_pkg::FUNC_W-1:0]        s_func,
    input  logic [pida_pkg::POS_W-1:0]         s_position,
    input  logic signed [pida_pkg::DATA_W-1:0] s_value,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [pida_pkg::DATA_W-1:0] m_data,
    output logic [CW-1:0]                      m_count,
    output logic [1:0]                         m_status
);

    logic                        cmd_valid_reg;
    logic [pida_pkg::FUNC_W-1:0] func_reg;
    logic [pida_pkg::POS_W-1:0]  pos_reg;
    logic [pida_pkg::DATA_W-1:0] value_reg;
    logic [CW-1:0]               count_reg;
    logic [CW-1:0]               count_next;
    logic                        out_valid_reg;
    logic [pida_pkg::DATA_W-1:0] data_reg;
    logic [CW-1:0]               out_count_reg;
    pida_pkg::status_t           status_reg;
    pida_pkg::ctrl_t             ctrl;
    pida_pkg::store_op_t         store_op;
    logic [pida_pkg::DATA_W-1:0] rd_data;
    logic                        advance;
    logic                        s_fire;

    assign advance  = cmd_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !cmd_valid_reg || advance;
    assign s_fire   = s_valid && s_ready;
    assign store_op = advance ? ctrl.op : pida_pkg::OP_NONE;

    pida_ctrl #(
        .CAPACITY(CAPACITY),
        .CW      (CW)
    ) u_ctrl (
        .func      (func_reg),
        .position  (pos_reg),
        .count     (count_reg),
        .ctrl      (ctrl),
        .count_next(count_next)
    );

    pida_store #(
        .CAPACITY(CAPACITY),
        .CW      (CW)
    ) u_store (
        .aclk    (aclk),
        .op      (store_op),
        .position(pos_reg),
        .count   (count_reg),
        .value   (value_reg),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end else begin
            if (s_fire) begin
                cmd_valid_reg <= 1'b1;
            end else if (advance) begin
                cmd_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                count_reg     <= count_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            func_reg  <= s_func;
            pos_reg   <= s_position;
            value_reg <= s_value;
        end
        if (advance) begin
            data_reg      <= ctrl.rd_en ? rd_data : '0;
            out_count_reg <= count_next;
            status_reg    <= ctrl.status;
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_data   = data_reg;
    assign m_count  = out_count_reg;
    assign m_status = status_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("Element count exceeds capacity.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && ctrl.status != pida_pkg::ST_OK |=> count_reg == $past(count_reg))
        else $error("A failed command changed the element count.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == pida_pkg::ST_FULL |-> m_count == CW'(CAPACITY))
        else $error("Full status reported with a count below capacity.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == pida_pkg::ST_EMPTY |-> m_count == '0 && m_data == '0)
        else $error("Empty status reported with a nonzero count or data.");

endmodule

### src/pida_ctrl.sv
// Command decoder: checks a command against the count and plans the array update.
module pida_ctrl #(
    parameter int unsigned CAPACITY = 16,
    parameter int unsigned CW = $clog2(CAPACITY + 1)
) (
    input  logic [pida_pkg::FUNC_W-1:0] func,
    input  logic [pida_pkg::POS_W-1:0]  position,
    input  logic [CW-1:0]               count,
    output pida_pkg::ctrl_t             ctrl,
    output logic [CW-1:0]               count_next
);

    localparam int unsigned CMPW = (CW > pida_pkg::POS_W) ? CW : pida_pkg::POS_W;

    logic            full;
    logic            empty;
    logic [CMPW-1:0] pos_ext;
    logic [CMPW-1:0] cnt_ext;

    assign full    = (count == CW'(CAPACITY));
    assign empty   = (count == '0);
    assign pos_ext = CMPW'(position);
    assign cnt_ext = CMPW'(count);

    always_comb begin
        ctrl.op     = pida_pkg::OP_NONE;
        ctrl.status = pida_pkg::ST_OK;
        ctrl.rd_en  = 1'b0;
        count_next  = count;
        unique case (func)
            pida_pkg::CMD_CLEAR: begin
                count_next = '0;
            end
            pida_pkg::CMD_APPEND: begin
                if (full) begin
                    ctrl.status = pida_pkg::ST_FULL;
                end else begin
                    ctrl.op    = pida_pkg::OP_APPEND;
                    count_next = count + CW'(1);
                end
            end
            pida_pkg::CMD_INSERT: begin
                if (full) begin
                    ctrl.status = pida_pkg::ST_FULL;
                end else if (pos_ext > cnt_ext) begin
                    ctrl.status = pida_pkg::ST_BADPOS;
                end else begin
                    ctrl.op    = pida_pkg::OP_INSERT;
                    count_next = count + CW'(1);
                end
            end
            pida_pkg::CMD_DELETE: begin
                if (empty) begin
                    ctrl.status = pida_pkg::ST_EMPTY;
                end else if (pos_ext >= cnt_ext) begin
                    ctrl.status = pida_pkg::ST_BADPOS;
                end else begin
                    ctrl.op    = pida_pkg::OP_DELETE;
                    ctrl.rd_en = 1'b1;
                    count_next = count - CW'(1);
                end
            end
            pida_pkg::CMD_READ: begin
                if (empty) begin
                    ctrl.status = pida_pkg::ST_EMPTY;
                end else if (pos_ext >= cnt_ext) begin
                    ctrl.status = pida_pkg::ST_BADPOS;
                end else begin
                    ctrl.rd_en = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

### src/pida_store.sv
// Entry registers with per-entry shift multiplexers and a positional read port.
module pida_store #(
    parameter int unsigned CAPACITY = 16,
    parameter int unsigned CW = $clog2(CAPACITY + 1)
) (
    input  logic                        aclk,
    input  pida_pkg::store_op_t         op,
    input  logic [pida_pkg::POS_W-1:0]  position,
    input  logic [CW-1:0]               count,
    input  logic [pida_pkg::DATA_W-1:0] value,
    output logic [pida_pkg::DATA_W-1:0] rd_data
);

    localparam int unsigned CMPW = (CW > pida_pkg::POS_W) ? CW : pida_pkg::POS_W;

    logic [pida_pkg::DATA_W-1:0] entries_reg  [CAPACITY];
    logic [pida_pkg::DATA_W-1:0] entries_next [CAPACITY];
    logic [CMPW-1:0]             pos_ext;
    logic [CMPW-1:0]             cnt_ext;

    assign pos_ext = CMPW'(position);
    assign cnt_ext = CMPW'(count);

    for (genvar i = 0; i < CAPACITY; i++) begin : g_entry
        logic [pida_pkg::DATA_W-1:0] below;
        logic [pida_pkg::DATA_W-1:0] above;
        logic [CMPW-1:0]             idx;

        assign idx = CMPW'(i);

        if (i == 0) begin : g_first
            assign below = entries_reg[i];
        end else begin : g_mid
            assign below = entries_reg[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign above = entries_reg[i];
        end else begin : g_up
            assign above = entries_reg[i+1];
        end

        always_comb begin
            entries_next[i] = entries_reg[i];
            case (op)
                pida_pkg::OP_APPEND: begin
                    if (idx == cnt_ext) begin
                        entries_next[i] = value;
                    end
                end
                pida_pkg::OP_INSERT: begin
                    if (idx > pos_ext) begin
                        entries_next[i] = below;
                    end else if (idx == pos_ext) begin
                        entries_next[i] = value;
                    end
                end
                pida_pkg::OP_DELETE: begin
                    if (idx >= pos_ext) begin
                        entries_next[i] = above;
                    end
                end
                default: begin
                end
            endcase
        end

        always_ff @(posedge aclk) begin
            entries_reg[i] <= entries_next[i];
        end
    end

    always_comb begin
        rd_data = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (CMPW'(i) == pos_ext) begin
                rd_data = entries_reg[i];
            end
        end
    end

endmodule
